FILE: rtl/core/qslerp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the quaternion slerp block.
// No dependencies; imported by quaternion_slerp.
package qslerp_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int IT_W = $clog2(ATAN_ENTRIES);

  localparam int XW  = 36;  // CORDIC x, y, z and angle registers
  localparam int SW  = 38;  // blend scales, multiplier operand A
  localparam int MBW = 29;  // multiplier operand B
  localparam int PW  = SW + MBW;
  localparam int AW  = 56;  // accumulator
  localparam int DW  = 74;  // divider remainder and shifted divisor
  localparam int QW  = 37;  // divider quotient bits
  localparam int RW  = 57;  // square root operand

  localparam logic signed [XW-1:0] ONE_Q28     = XW'(268435456);
  localparam logic signed [XW-1:0] PI_Q28      = XW'(843314857);
  localparam logic signed [XW-1:0] HALF_PI_Q28 = XW'(421657428);
  localparam logic signed [XW-1:0] TWO_PI_Q28  = XW'(1686629713);
  localparam logic signed [SW-1:0] SCALE_LIMIT = SW'(64'sd68719476736);

  localparam logic [14:0] NEAR_THRESHOLD_RESET = 15'd16;
  localparam logic        REG_NEAR_THRESHOLD   = 1'b0;

  localparam logic [28:0] ATAN_Q28 [ATAN_ENTRIES] = '{
    29'd210828714, 29'd124459457, 29'd65760959, 29'd33381290, 29'd16755422, 29'd8385879,
    29'd4193963, 29'd2097109, 29'd1048571, 29'd524287, 29'd262144, 29'd131072,
    29'd65536, 29'd32768, 29'd16384, 29'd8192, 29'd4096, 29'd2048,
    29'd1024, 29'd512, 29'd256, 29'd128, 29'd64, 29'd32
  };

  typedef enum logic [3:0] {
    ST_IDLE, ST_DOT, ST_DECIDE, ST_SQ, ST_SQRT, ST_ANG, ST_SIN_SEL, ST_MT_TAKE,
    ST_RED, ST_ROT, ST_SIN_DONE, ST_DIV_INIT, ST_DIV, ST_DIV_FIN, ST_BLEND, ST_FIN
  } state_t;

endpackage

FILE: rtl/core/quaternion_slerp.sv
`timescale 1ns / 1ps
// Quaternion slerp top level: sequencer, shared multiplier, CORDIC, root and divider.
// Depends on qslerp_pkg.
//
// Use: the in_ stream carries one beat per interpolation (start and end quaternion in
// signed Q2.14, position t in Q1.14). Each beat yields exactly one out_ beat with the
// interpolated quaternion, rounded and saturated to Q2.14. The cfg_ APB port holds
// near_threshold at byte address 0; pready is always high, writes land on the access
// cycle.
// Latency depends on the branch taken (linear blend, antipodal blend or full slerp) and
// grows with each angle wrap; a clamped scale skips its divider pass.
// It is set by the 16-step CORDIC pass run once for acos and once per sine,
// the 37-step restoring divider run for each of the two scales, and the 29-step root.
// One beat is in work at a time; in_tready is high only while the sequencer is idle,
// so the next beat can be taken in the cycle after a result is loaded.
// A finished result sits in the output register; the next beat is taken while it
// waits. If the receiver stalls, a second result holds in the sequencer until the
// output register drains.
// Reset: synchronous, active low; clears the sequencer and out_tvalid and sets
// near_threshold to 16.
module quaternion_slerp import qslerp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // from_x, from_y, from_z, from_w, to_x, to_y, to_z, to_w (16 each), position (15), pad
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_z, out_w (16 each)
  output logic [63:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  state_t state_r, state_nxt;

  logic [14:0]             thr_r;
  logic signed [16:0]      f_r [4];
  logic signed [15:0]      q_r [4];
  logic [14:0]             t_r;
  logic signed [AW-1:0]    acc_r;
  logic signed [PW-1:0]    prod_r;
  logic [32:0]             c_r;
  logic                    anti_r;
  logic signed [XW-1:0]    x_r, y_r, z_r, w_r, den_r, na_r, nb_r;
  logic [IT_W-1:0]         iter_r;
  logic [5:0]              cnt_r;
  logic [1:0]              k_r;
  logic                    dk_r;
  logic [RW-1:0]           n_r, r_r;
  logic [DW-1:0]           rem_r, dreg_r;
  logic [QW-1:0]           quo_r;
  logic                    dneg_r;
  logic signed [SW-1:0]    sa_r, sb_r;
  logic signed [15:0]      res_r [4];
  logic [63:0]             out_data_r;
  logic                    out_valid_r;

  logic signed [SW-1:0]    mul_a;
  logic signed [MBW-1:0]   mul_b;

  // cordic micro-rotation
  logic signed [XW-1:0]    sh_x, sh_y, atan_v, x_step, y_step, z_step;
  logic                    rot_neg, cordic_last;
  // square root step
  logic [RW-1:0]           sq_bit, sq_sum, sq_r_nxt;
  logic                    sq_ge;
  // divider
  logic [DW-1:0]           dv_d, dv_dividend, dv_dtop;
  logic                    dv_ge, dv_ovf;
  logic signed [XW-1:0]    dv_num;
  logic [XW-1:0]           dv_mag;
  logic signed [SW-1:0]    dv_qmag, dv_scale, dv_ovf_scale;
  // branch choice
  logic signed [33:0]      dot;
  logic [32:0]             c_abs;
  logic [28:0]             eps;
  logic [34:0]             lin_diff;
  logic                    anti_hit, lin_hit;
  logic signed [16:0]      tdiff;
  logic signed [SW-1:0]    lin_sa, lin_sb;
  logic signed [MBW-1:0]   tfac;
  // blend and angle product
  logic signed [AW-1:0]    b_first, b_sum, b_sh;
  logic signed [15:0]      b_sat;
  logic signed [PW-1:0]    mt_full;
  logic                    fin_load;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_NEAR_THRESHOLD) ? {17'd0, thr_r} : 32'd0;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    sh_x        = x_r >>> iter_r;
    sh_y        = y_r >>> iter_r;
    rot_neg     = (state_r == ST_ANG) ? (y_r > 0) : (z_r < 0);
    atan_v      = XW'($signed({1'b0, ATAN_Q28[iter_r]}));
    x_step      = rot_neg ? x_r + sh_y : x_r - sh_y;
    y_step      = rot_neg ? y_r - sh_x : y_r + sh_x;
    z_step      = rot_neg ? z_r + atan_v : z_r - atan_v;
    cordic_last = (iter_r == IT_W'(CORDIC_STEPS - 1));

    sq_bit   = RW'(1) << {cnt_r[4:0], 1'b0};
    sq_sum   = r_r + sq_bit;
    sq_ge    = (n_r >= sq_sum);
    sq_r_nxt = sq_ge ? (r_r >> 1) + sq_bit : (r_r >> 1);

    dv_d         = dreg_r >> 1;
    dv_ge        = (rem_r >= dv_d);
    dv_num       = dk_r ? nb_r : na_r;
    dv_mag       = (dv_num < 0) ? XW'(-dv_num) : XW'(dv_num);
    dv_dividend  = DW'(dv_mag) << 28;
    dv_dtop      = DW'(den_r) << QW;
    dv_ovf       = (dv_dividend >= dv_dtop);
    dv_ovf_scale = (dv_num < 0) ? -SCALE_LIMIT : SCALE_LIMIT;
    dv_qmag      = (SW'(quo_r) > SCALE_LIMIT) ? SCALE_LIMIT : SW'(quo_r);
    dv_scale     = dneg_r ? -dv_qmag : dv_qmag;

    dot      = acc_r[33:0];
    c_abs    = (dot < 0) ? 33'(-dot) : 33'(dot);
    eps      = {thr_r, 14'd0};
    anti_hit = ((34'(ONE_Q28) + 34'(c_abs)) <= 34'(eps));
    lin_diff = 35'(ONE_Q28) - 35'(c_abs);
    lin_hit  = ($signed(lin_diff) <= $signed({6'd0, eps}));
    tdiff    = $signed(17'd16384 - {2'b0, t_r});
    lin_sa   = SW'(tdiff) <<< 14;
    lin_sb   = SW'({t_r, 14'd0});

    if (k_r == 2'd1) begin
      tfac = anti_r ? MBW'($signed(17'd8192 - {2'b0, t_r})) : MBW'(tdiff);
    end else begin
      tfac = MBW'($signed({1'b0, t_r}));
    end

    b_first = prod_r[AW-1:0] + AW'(64'sd134217728);
    b_sum   = acc_r + prod_r[AW-1:0];
    b_sh    = b_sum >>> 28;
    if (b_sh > AW'(32767)) begin
      b_sat = 16'sd32767;
    end else if (b_sh < -AW'(32768)) begin
      b_sat = -16'sd32768;
    end else begin
      b_sat = b_sh[15:0];
    end

    mt_full  = (prod_r + PW'(8192)) >>> 14;
    fin_load = (state_r == ST_FIN) && (!out_valid_r || out_tready);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_tvalid) state_nxt = ST_DOT;
      ST_DOT:      if (cnt_r == 6'd4) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (anti_hit) state_nxt = ST_SIN_SEL;
        else if (lin_hit) state_nxt = ST_BLEND;
        else state_nxt = ST_SQ;
      end
      ST_SQ:       if (cnt_r == 6'd1) state_nxt = ST_SQRT;
      ST_SQRT:     if (cnt_r == 6'd0) state_nxt = ST_ANG;
      ST_ANG:      if (cordic_last) state_nxt = ST_SIN_SEL;
      ST_SIN_SEL:  state_nxt = (k_r == 2'd0) ? ST_RED : ST_MT_TAKE;
      ST_MT_TAKE:  state_nxt = ST_RED;
      ST_RED: begin
        if (!(z_r > PI_Q28) && !(z_r < -PI_Q28)) state_nxt = ST_ROT;
      end
      ST_ROT:      if (cordic_last) state_nxt = ST_SIN_DONE;
      ST_SIN_DONE: begin
        if (k_r == 2'd0 && !anti_r && y_r <= 0) state_nxt = ST_BLEND;
        else if (k_r == 2'd2) state_nxt = ST_DIV_INIT;
        else state_nxt = ST_SIN_SEL;
      end
      ST_DIV_INIT: begin
        if (!dv_ovf) state_nxt = ST_DIV;
        else if (dk_r) state_nxt = ST_BLEND;
      end
      ST_DIV:      if (cnt_r == 6'(QW - 1)) state_nxt = ST_DIV_FIN;
      ST_DIV_FIN:  state_nxt = dk_r ? ST_BLEND : ST_DIV_INIT;
      ST_BLEND:    if (cnt_r == 6'd8) state_nxt = ST_FIN;
      ST_FIN:      if (fin_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs: handshake and shared multiplier operands
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_DOT: begin
        case (cnt_r[1:0])
          2'd0:    begin mul_a = SW'(f_r[0]); mul_b = MBW'(q_r[0]); end
          2'd1:    begin mul_a = SW'(f_r[1]); mul_b = MBW'(q_r[1]); end
          2'd2:    begin mul_a = SW'(f_r[2]); mul_b = MBW'(q_r[2]); end
          default: begin mul_a = SW'(f_r[3]); mul_b = MBW'(q_r[3]); end
        endcase
      end
      ST_SQ: begin
        mul_a = $signed({5'd0, c_r});
        mul_b = $signed(c_r[28:0]);
      end
      ST_SIN_SEL: begin
        mul_a = anti_r ? SW'(PI_Q28) : SW'(w_r);
        mul_b = tfac;
      end
      ST_BLEND: begin
        case (cnt_r[2:0])
          3'd0: begin mul_a = sa_r; mul_b = MBW'(f_r[0]); end
          3'd1: begin
            mul_a = anti_r ? -sb_r : sb_r;
            mul_b = anti_r ? MBW'(f_r[1]) : MBW'(q_r[0]);
          end
          3'd2: begin mul_a = sa_r; mul_b = MBW'(f_r[1]); end
          3'd3: begin
            mul_a = sb_r;
            mul_b = anti_r ? MBW'(f_r[0]) : MBW'(q_r[1]);
          end
          3'd4: begin mul_a = sa_r; mul_b = MBW'(f_r[2]); end
          3'd5: begin
            mul_a = anti_r ? -sb_r : sb_r;
            mul_b = anti_r ? MBW'(f_r[3]) : MBW'(q_r[2]);
          end
          3'd6: begin mul_a = sa_r; mul_b = MBW'(f_r[3]); end
          default: begin
            mul_a = sb_r;
            mul_b = anti_r ? MBW'(f_r[2]) : MBW'(q_r[3]);
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= NEAR_THRESHOLD_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      iter_r      <= '0;
      k_r         <= '0;
      dk_r        <= 1'b0;
      anti_r      <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == REG_NEAR_THRESHOLD) begin
        thr_r <= cfg_pwdata[14:0];
      end

      if (fin_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {res_r[3], res_r[2], res_r[1], res_r[0]};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            f_r[0] <= 17'($signed(in_tdata[15:0]));
            f_r[1] <= 17'($signed(in_tdata[31:16]));
            f_r[2] <= 17'($signed(in_tdata[47:32]));
            f_r[3] <= 17'($signed(in_tdata[63:48]));
            q_r[0] <= in_tdata[79:64];
            q_r[1] <= in_tdata[95:80];
            q_r[2] <= in_tdata[111:96];
            q_r[3] <= in_tdata[127:112];
            t_r    <= in_tdata[142:128];
            cnt_r  <= '0;
            acc_r  <= '0;
          end
        end
        ST_DOT: begin
          if (cnt_r != 6'd0) acc_r <= acc_r + prod_r[AW-1:0];
          cnt_r <= cnt_r + 6'd1;
        end
        ST_DECIDE: begin
          c_r    <= c_abs;
          anti_r <= anti_hit;
          k_r    <= '0;
          cnt_r  <= '0;
          if (dot < 0) begin
            f_r[0] <= -f_r[0];
            f_r[1] <= -f_r[1];
            f_r[2] <= -f_r[2];
            f_r[3] <= -f_r[3];
          end
          sa_r <= lin_sa;
          sb_r <= lin_sb;
        end
        ST_SQ: begin
          if (cnt_r == 6'd1) begin
            n_r   <= (RW'(1) << 56) - prod_r[RW-1:0];
            r_r   <= '0;
            cnt_r <= 6'd28;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        ST_SQRT: begin
          if (sq_ge) n_r <= n_r - sq_sum;
          r_r   <= sq_r_nxt;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            x_r    <= XW'(c_r);
            y_r    <= XW'(sq_r_nxt);
            z_r    <= '0;
            iter_r <= '0;
          end
        end
        ST_ANG, ST_ROT: begin
          x_r    <= x_step;
          y_r    <= y_step;
          z_r    <= z_step;
          iter_r <= iter_r + IT_W'(1);
          if (state_r == ST_ANG && cordic_last) begin
            w_r <= z_step;
          end
        end
        ST_SIN_SEL: begin
          if (k_r == 2'd0) z_r <= anti_r ? HALF_PI_Q28 : w_r;
        end
        ST_MT_TAKE: begin
          z_r <= mt_full[XW-1:0];
        end
        ST_RED: begin
          if (z_r > PI_Q28) begin
            z_r <= z_r - TWO_PI_Q28;
          end else if (z_r < -PI_Q28) begin
            z_r <= z_r + TWO_PI_Q28;
          end else begin
            if (z_r > HALF_PI_Q28) z_r <= PI_Q28 - z_r;
            else if (z_r < -HALF_PI_Q28) z_r <= -PI_Q28 - z_r;
            x_r    <= ONE_Q28;
            y_r    <= '0;
            iter_r <= '0;
          end
        end
        ST_SIN_DONE: begin
          case (k_r)
            2'd0:    den_r <= (y_r <= 0) ? XW'(1) : y_r;
            2'd1:    na_r <= y_r;
            default: nb_r <= y_r;
          endcase
          k_r   <= k_r + 2'd1;
          dk_r  <= 1'b0;
          cnt_r <= '0;
        end
        ST_DIV_INIT: begin
          rem_r  <= dv_dividend;
          dreg_r <= dv_dtop;
          dneg_r <= (dv_num < 0);
          quo_r  <= '0;
          cnt_r  <= '0;
          if (dv_ovf) begin
            if (dk_r) sb_r <= dv_ovf_scale;
            else sa_r <= dv_ovf_scale;
            dk_r <= 1'b1;
          end
        end
        ST_DIV: begin
          dreg_r <= dv_d;
          if (dv_ge) rem_r <= rem_r - dv_d;
          quo_r <= {quo_r[QW-2:0], dv_ge};
          cnt_r <= cnt_r + 6'd1;
        end
        ST_DIV_FIN: begin
          if (dk_r) sb_r <= dv_scale;
          else sa_r <= dv_scale;
          dk_r  <= 1'b1;
          cnt_r <= '0;
        end
        ST_BLEND: begin
          if (cnt_r != 6'd0) begin
            if (!cnt_r[0]) begin
              res_r[cnt_r[2:1] - 2'd1] <= b_sat;
            end else begin
              acc_r <= b_first;
            end
          end
          cnt_r <= cnt_r + 6'd1;
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("in_tready high right after an accepted beat");

  a_cordic_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROT || state_r == ST_ANG) |-> (iter_r < IT_W'(CORDIC_STEPS)))
    else $error("cordic step index out of range");

  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_INIT || state_r == ST_DIV) |-> (den_r > 0))
    else $error("divider entered with non-positive divisor");

  a_scale_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BLEND) |-> (sa_r <= SCALE_LIMIT && sa_r >= -SCALE_LIMIT &&
                              sb_r <= SCALE_LIMIT && sb_r >= -SCALE_LIMIT))
    else $error("blend scale outside clamp range");

endmodule
